@@ src/lic3_pkg.sv @@
// Shared constants, codes and types for the 3D line inlier counter.
`timescale 1ns / 1ps
`default_nettype none

package lic3_pkg;

    // Geometry and count sizing
    localparam int COORD_BITS = 18;
    localparam int MAX_POINTS = 4096;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int FRAC_BITS  = 16;
    localparam int RATE_W     = FRAC_BITS + 1;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    // Datapath widths of the shared multiply-accumulate unit
    localparam int V_W     = COORD_BITS + 1;    // point minus base
    localparam int HALF_W  = COORD_BITS + 1;    // half of a magnitude word
    localparam int MAG_W   = 2 * HALF_W;        // cross term magnitude
    localparam int CROSS_W = MAG_W;             // signed cross term
    localparam int OP_W    = HALF_W + 1;        // signed multiplier operand
    localparam int PROD_W  = 2 * OP_W;
    localparam int ACC_W   = 2 * MAG_W + 4;     // holds lhs - rhs

    // Stream widths, packed to whole bytes
    localparam int S_DATA_W = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int M_FLD_W  = 1 + 2 * CNT_W + RATE_W;
    localparam int M_DATA_W = ((M_FLD_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam int NUM_REGS  = 7;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam logic [REG_IDX_W-1:0] REG_BASE_X   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BASE_Y   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BASE_Z   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DIR_X    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MAX_DIST = 3'd6;

    // MAC operations
    localparam int MAC_OP_W = 3;
    localparam logic [MAC_OP_W-1:0] MAC_NOP    = 3'd0;
    localparam logic [MAC_OP_W-1:0] MAC_LOAD   = 3'd1;  // cross = a*b
    localparam logic [MAC_OP_W-1:0] MAC_SUB    = 3'd2;  // mag = |cross - a*b|
    localparam logic [MAC_OP_W-1:0] MAC_SQ_LO  = 3'd3;  // acc +/-= lo*lo
    localparam logic [MAC_OP_W-1:0] MAC_SQ_MID = 3'd4;  // acc +/-= 2*hi*lo
    localparam logic [MAC_OP_W-1:0] MAC_SQ_HI  = 3'd5;  // acc +/-= hi*hi

    typedef struct packed {
        logic                clr;
        logic [MAC_OP_W-1:0] op;
        logic                neg;
    } mac_ctrl_t;

endpackage

`default_nettype wire

@@ src/lic3_mac.sv @@
// Shared multiplier with cross term, magnitude and wide accumulator stages.
`timescale 1ns / 1ps
`default_nettype none

module lic3_mac
    import lic3_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire mac_ctrl_t               ctrl,
    input  wire logic signed [OP_W-1:0]  op_a,
    input  wire logic signed [OP_W-1:0]  op_b,
    output logic                         le_zero
);

    logic signed [OP_W-1:0]   mul_a;
    logic signed [OP_W-1:0]   mul_b;
    logic signed [OP_W-1:0]   lo_ext;
    logic signed [OP_W-1:0]   hi_ext;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic [MAC_OP_W-1:0]      act_reg;
    logic                     neg_reg;
    logic [CROSS_W-1:0]       cross_reg;
    logic [CROSS_W-1:0]       diff;
    logic [MAG_W-1:0]         mag_reg;
    logic [MAG_W-1:0]         mag_next;
    logic [ACC_W-1:0]         prod_ext;
    logic [ACC_W-1:0]         term;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;

    // Halves of the stored magnitude as non-negative operands
    assign lo_ext = {{(OP_W-HALF_W){1'b0}}, mag_reg[HALF_W-1:0]};
    assign hi_ext = {{(OP_W-HALF_W){1'b0}}, mag_reg[MAG_W-1:HALF_W]};

    // Issue stage: operand select and the one multiplier
    always_comb
    begin
        mul_a = op_a;
        mul_b = op_b;
        case (ctrl.op)
            MAC_SQ_LO:
            begin
                mul_a = lo_ext;
                mul_b = lo_ext;
            end
            MAC_SQ_MID:
            begin
                mul_a = hi_ext;
                mul_b = lo_ext;
            end
            MAC_SQ_HI:
            begin
                mul_a = hi_ext;
                mul_b = hi_ext;
            end
            default:
            begin
                mul_a = op_a;
                mul_b = op_b;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= MAC_NOP;
            neg_reg <= 1'b0;
        end
        else
        begin
            act_reg <= ctrl.op;
            neg_reg <= ctrl.neg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Action stage: cross difference and its magnitude
    assign diff     = cross_reg - prod_reg[CROSS_W-1:0];
    assign mag_next = diff[CROSS_W-1] ? (~diff + {{(MAG_W-1){1'b0}}, 1'b1}) : diff;

    always_ff @(posedge clk)
    begin
        if (act_reg == MAC_LOAD)
        begin
            cross_reg <= prod_reg[CROSS_W-1:0];
        end
        if (act_reg == MAC_SUB)
        begin
            mag_reg <= mag_next;
        end
    end

    // Action stage: weighted partial square into the accumulator
    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        case (act_reg)
            MAC_SQ_MID: term = prod_ext << (HALF_W + 1);
            MAC_SQ_HI:  term = prod_ext << (2 * HALF_W);
            default:    term = prod_ext;
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clr)
        begin
            acc_next = '0;
        end
        else if (act_reg == MAC_SQ_LO || act_reg == MAC_SQ_MID || act_reg == MAC_SQ_HI)
        begin
            acc_next = neg_reg ? (acc_reg - term) : (acc_reg + term);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Accumulator holds |VxD|^2 - T^2*|D|^2
    assign le_zero = acc_reg[ACC_W-1] | (acc_reg == '0);

endmodule

`default_nettype wire

@@ src/lic3_div.sv @@
// Restoring divider, one quotient bit per cycle, for the inlier fraction.
`timescale 1ns / 1ps
`default_nettype none

module lic3_div
    import lic3_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [CNT_W-1:0]  num,
    input  wire logic [CNT_W-1:0]  den,
    output logic                   done,
    output logic [RATE_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(RATE_W + 1);
    localparam logic [STEP_W-1:0] STEP_ONE  = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_FULL = STEP_W'(RATE_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W:0]    rem_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [RATE_W-1:0] quo_reg;
    logic              ge;
    logic [CNT_W:0]    rem_sub;

    // Trial subtract; numerator <= denominator so the first bit is the integer part
    assign ge      = rem_reg >= {1'b0, den_reg};
    assign rem_sub = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == STEP_ONE);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_FULL;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_ONE;
                if (step_reg == STEP_ONE)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= {rem_sub[CNT_W-1:0], 1'b0};
            quo_reg <= {quo_reg[RATE_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ src/line_inlier_counter_3d.sv @@
// Top level: configuration, sequencer, cloud counters and result register.
`timescale 1ns / 1ps
`default_nettype none

// Tests each 3D point against a configured line (base point, direction) by the
// exact squared form |(P-B) x D|^2 <= T^2 * |D|^2 and keeps running inlier and
// point counts; a zero direction makes every point an outlier. One 20x20-bit
// multiplier is shared over six terms (three cross components, three bound
// components), each taking six issue slots; a drain state and a count state
// follow before a result is offered, and the block is ready for the next item
// from the cycle in which the result is offered. The count state holds while
// an earlier result still waits in the output register. On the item marked
// last a serial divider then works out the inlier fraction (65536 = 1.0)
// before that result is offered; both counts clear as that item is counted.
// Counts stop at 4096. A finished result waits in the output register while
// the next item is taken; configuration is to be written only while the block
// is idle.
module line_inlier_counter_3d
    import lic3_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic [REG_IDX_W-1:0]  cfg_index,
    input  wire logic [COORD_BITS-1:0] cfg_data,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // point_x, point_y, point_z
    input  wire logic                  s_tlast,   // last_point
    // result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,   // is_inlier, inlier_count,
                                                  // point_count, inlier_frac
    output logic                       m_tlast    // cloud_done
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CALC  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_COUNT = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;

    // Terms: three cross components, then the three bound components
    localparam logic [2:0] COMP_CROSS_X = 3'd0;
    localparam logic [2:0] COMP_CROSS_Y = 3'd1;
    localparam logic [2:0] COMP_CROSS_Z = 3'd2;
    localparam logic [2:0] COMP_BOUND_X = 3'd3;
    localparam logic [2:0] COMP_BOUND_Y = 3'd4;
    localparam logic [2:0] COMP_BOUND_Z = 3'd5;

    // Issue slots within one term
    localparam logic [2:0] SLOT_LOAD   = 3'd0;
    localparam logic [2:0] SLOT_SUB    = 3'd1;
    localparam logic [2:0] SLOT_GAP    = 3'd2;
    localparam logic [2:0] SLOT_SQ_LO  = 3'd3;
    localparam logic [2:0] SLOT_SQ_MID = 3'd4;
    localparam logic [2:0] SLOT_SQ_HI  = 3'd5;

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [2:0]             comp_reg;
    logic [2:0]             slot_reg;

    logic [COORD_BITS-1:0]  base_x_reg;
    logic [COORD_BITS-1:0]  base_y_reg;
    logic [COORD_BITS-1:0]  base_z_reg;
    logic [COORD_BITS-1:0]  dir_x_reg;
    logic [COORD_BITS-1:0]  dir_y_reg;
    logic [COORD_BITS-1:0]  dir_z_reg;
    logic [COORD_BITS-2:0]  max_dist_reg;

    logic [COORD_BITS-1:0]  pt_x;
    logic [COORD_BITS-1:0]  pt_y;
    logic [COORD_BITS-1:0]  pt_z;
    logic [V_W-1:0]         vx_reg;
    logic [V_W-1:0]         vy_reg;
    logic [V_W-1:0]         vz_reg;
    logic                   last_reg;

    logic [CNT_W-1:0]       inlier_total_reg;
    logic [CNT_W-1:0]       point_total_reg;
    logic [CNT_W-1:0]       it_new;
    logic [CNT_W-1:0]       pt_new;

    logic                   out_valid_reg;
    logic                   out_inl_reg;
    logic [CNT_W-1:0]       out_it_reg;
    logic [CNT_W-1:0]       out_pt_reg;
    logic [RATE_W-1:0]      out_rate_reg;
    logic                   out_done_reg;

    logic                   accept;
    logic                   out_free;
    logic                   count_fire;
    logic                   dir_zero;
    logic                   inl;
    logic                   le_zero;
    logic                   div_done;
    logic [RATE_W-1:0]      div_quo;

    mac_ctrl_t              mac_ctrl;
    logic signed [OP_W-1:0] ext_vx;
    logic signed [OP_W-1:0] ext_vy;
    logic signed [OP_W-1:0] ext_vz;
    logic signed [OP_W-1:0] ext_dx;
    logic signed [OP_W-1:0] ext_dy;
    logic signed [OP_W-1:0] ext_dz;
    logic signed [OP_W-1:0] ext_t;
    logic signed [OP_W-1:0] ld_a;
    logic signed [OP_W-1:0] ld_b;
    logic signed [OP_W-1:0] sb_a;
    logic signed [OP_W-1:0] sb_b;
    logic signed [OP_W-1:0] op_a;
    logic signed [OP_W-1:0] op_b;

    // Handshake
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign count_fire = (state_reg == ST_COUNT) && out_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_x_reg   <= '0;
            base_y_reg   <= '0;
            base_z_reg   <= '0;
            dir_x_reg    <= '0;
            dir_y_reg    <= '0;
            dir_z_reg    <= '0;
            max_dist_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_X:   base_x_reg   <= cfg_data;
                REG_BASE_Y:   base_y_reg   <= cfg_data;
                REG_BASE_Z:   base_z_reg   <= cfg_data;
                REG_DIR_X:    dir_x_reg    <= cfg_data;
                REG_DIR_Y:    dir_y_reg    <= cfg_data;
                REG_DIR_Z:    dir_z_reg    <= cfg_data;
                REG_MAX_DIST: max_dist_reg <= cfg_data[COORD_BITS-2:0];
                default:      ;
            endcase
        end
    end

    assign dir_zero = (dir_x_reg == '0) && (dir_y_reg == '0) && (dir_z_reg == '0);

    // Capture point minus base on accept
    assign pt_x = s_tdata[COORD_BITS-1:0];
    assign pt_y = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign pt_z = s_tdata[3*COORD_BITS-1:2*COORD_BITS];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vx_reg   <= {pt_x[COORD_BITS-1], pt_x} - {base_x_reg[COORD_BITS-1], base_x_reg};
            vy_reg   <= {pt_y[COORD_BITS-1], pt_y} - {base_y_reg[COORD_BITS-1], base_y_reg};
            vz_reg   <= {pt_z[COORD_BITS-1], pt_z} - {base_z_reg[COORD_BITS-1], base_z_reg};
            last_reg <= s_tlast;
        end
    end

    // Operands extended to the multiplier width; T zero extended, the rest sign extended
    assign ext_vx = {{(OP_W-V_W){vx_reg[V_W-1]}}, vx_reg};
    assign ext_vy = {{(OP_W-V_W){vy_reg[V_W-1]}}, vy_reg};
    assign ext_vz = {{(OP_W-V_W){vz_reg[V_W-1]}}, vz_reg};
    assign ext_dx = {{(OP_W-COORD_BITS){dir_x_reg[COORD_BITS-1]}}, dir_x_reg};
    assign ext_dy = {{(OP_W-COORD_BITS){dir_y_reg[COORD_BITS-1]}}, dir_y_reg};
    assign ext_dz = {{(OP_W-COORD_BITS){dir_z_reg[COORD_BITS-1]}}, dir_z_reg};
    assign ext_t  = {{(OP_W-COORD_BITS+1){1'b0}}, max_dist_reg};

    // Per term: loaded product and subtracted product
    always_comb
    begin
        ld_a = ext_t;
        ld_b = ext_dx;
        sb_a = '0;
        sb_b = '0;
        case (comp_reg)
            COMP_CROSS_X:
            begin
                ld_a = ext_vy;
                ld_b = ext_dz;
                sb_a = ext_vz;
                sb_b = ext_dy;
            end
            COMP_CROSS_Y:
            begin
                ld_a = ext_vz;
                ld_b = ext_dx;
                sb_a = ext_vx;
                sb_b = ext_dz;
            end
            COMP_CROSS_Z:
            begin
                ld_a = ext_vx;
                ld_b = ext_dy;
                sb_a = ext_vy;
                sb_b = ext_dx;
            end
            COMP_BOUND_X:
            begin
                ld_a = ext_t;
                ld_b = ext_dx;
            end
            COMP_BOUND_Y:
            begin
                ld_a = ext_t;
                ld_b = ext_dy;
            end
            COMP_BOUND_Z:
            begin
                ld_a = ext_t;
                ld_b = ext_dz;
            end
            default:
            begin
                ld_a = '0;
                ld_b = '0;
            end
        endcase
    end

    assign op_a = (slot_reg == SLOT_SUB) ? sb_a : ld_a;
    assign op_b = (slot_reg == SLOT_SUB) ? sb_b : ld_b;

    // MAC control for the current slot
    always_comb
    begin
        mac_ctrl.clr = accept;
        mac_ctrl.neg = (comp_reg >= COMP_BOUND_X);
        mac_ctrl.op  = MAC_NOP;
        if (state_reg == ST_CALC)
        begin
            case (slot_reg)
                SLOT_LOAD:   mac_ctrl.op = MAC_LOAD;
                SLOT_SUB:    mac_ctrl.op = MAC_SUB;
                SLOT_GAP:    mac_ctrl.op = MAC_NOP;    // magnitude settles
                SLOT_SQ_LO:  mac_ctrl.op = MAC_SQ_LO;
                SLOT_SQ_MID: mac_ctrl.op = MAC_SQ_MID;
                SLOT_SQ_HI:  mac_ctrl.op = MAC_SQ_HI;
                default:     mac_ctrl.op = MAC_NOP;
            endcase
        end
    end

    lic3_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .op_a    (op_a),
        .op_b    (op_b),
        .le_zero (le_zero)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (slot_reg == SLOT_SQ_HI && comp_reg == COMP_BOUND_Z)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COUNT;
            end
            ST_COUNT:
            begin
                if (out_free)
                begin
                    state_next = last_reg ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            comp_reg  <= COMP_CROSS_X;
            slot_reg  <= SLOT_LOAD;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                comp_reg <= COMP_CROSS_X;
                slot_reg <= SLOT_LOAD;
            end
            else if (state_reg == ST_CALC)
            begin
                if (slot_reg == SLOT_SQ_HI)
                begin
                    slot_reg <= SLOT_LOAD;
                    comp_reg <= comp_reg + 3'd1;
                end
                else
                begin
                    slot_reg <= slot_reg + 3'd1;
                end
            end
        end
    end

    // Saturating cloud counters
    assign inl = le_zero && !dir_zero;

    always_comb
    begin
        pt_new = point_total_reg;
        it_new = inlier_total_reg;
        if (point_total_reg < CNT_MAX)
        begin
            pt_new = point_total_reg + CNT_ONE;
            if (inl && inlier_total_reg < CNT_MAX)
            begin
                it_new = inlier_total_reg + CNT_ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inlier_total_reg <= '0;
            point_total_reg  <= '0;
        end
        else if (count_fire)
        begin
            inlier_total_reg <= last_reg ? '0 : it_new;
            point_total_reg  <= last_reg ? '0 : pt_new;
        end
    end

    lic3_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (count_fire && last_reg),
        .num      (it_new),
        .den      (pt_new),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (count_fire)
        begin
            out_valid_reg <= !last_reg;
        end
        else if (div_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (count_fire)
        begin
            out_inl_reg  <= inl;
            out_it_reg   <= it_new;
            out_pt_reg   <= pt_new;
            out_rate_reg <= '0;
            out_done_reg <= last_reg;
        end
        else if (div_done)
        begin
            out_rate_reg <= div_quo;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({out_rate_reg, out_pt_reg, out_it_reg, out_inl_reg});
    assign m_tlast  = out_done_reg;

    // Checks
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item taken while another is in progress");

    a_rate_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_done_reg) |-> (out_rate_reg == '0))
        else $error("inlier fraction set on an item that does not close the cloud");

    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_it_reg <= out_pt_reg && out_pt_reg != '0))
        else $error("inlier count exceeds point count or point count is zero");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

endmodule

`default_nettype wire
